FILE: rtl/kalman_cv_tracker_unit_macros.svh
`ifndef KALMAN_CV_TRACKER_UNIT_MACROS_SVH
`define KALMAN_CV_TRACKER_UNIT_MACROS_SVH

// check a condition in the cycle after a trigger
`define KCV_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

// check a condition in the same cycle as a trigger
`define KCV_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

`endif

FILE: rtl/kcv_pkg.sv
`default_nettype none
package kcv_pkg;

  localparam int DataW = 32;
  localparam int VarW  = 31;
  localparam int TsW   = 21;
  localparam int ChanW = 3;
  localparam int DivW  = 48;

  localparam logic [TsW-1:0] TsReset = 21'd655;

  localparam logic ActPredict = 1'b0;
  localparam logic ActUpdate  = 1'b1;

  localparam logic signed [63:0] QMax64 = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] QMin64 = 64'shffff_ffff_8000_0000;

  typedef struct packed {
    logic                    action;
    logic [ChanW-1:0]        channel;
    logic signed [DataW-1:0] measurement;
    logic [VarW-1:0]         meas_noise;
    logic [VarW-1:0]         proc_noise_pos;
    logic [VarW-1:0]         proc_noise_vel;
  } kcv_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] est_pos;
    logic signed [DataW-1:0] est_vel;
    logic signed [DataW-1:0] pred_pos;
    logic signed [DataW-1:0] pred_vel;
    logic signed [DataW-1:0] p11;
    logic signed [DataW-1:0] p12;
    logic signed [DataW-1:0] p22;
  } kcv_row_t;

  typedef struct packed {
    logic            start;
    logic            neg;
    logic [DivW-1:0] mag;
    logic [31:0]     den;
  } kcv_div_req_t;

  typedef struct packed {
    logic valid;
    logic full;
  } kcv_q_sts_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } kcv_bk_sts_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    if (v > QMax64) begin
      return QMax64[DataW-1:0];
    end else if (v < QMin64) begin
      return QMin64[DataW-1:0];
    end
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] qfix(input logic signed [63:0] p);
    return sat32(p >>> 16);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/kcv_if.sv
`default_nettype none
interface kcv_in_if import kcv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [ChanW-1:0]        channel;
  logic signed [DataW-1:0] measurement;
  logic [VarW-1:0]         meas_noise;
  logic [VarW-1:0]         proc_noise_pos;
  logic [VarW-1:0]         proc_noise_vel;
  modport source (output valid, action, channel, measurement, meas_noise,
                  proc_noise_pos, proc_noise_vel, input ready);
  modport sink (input valid, action, channel, measurement, meas_noise,
                proc_noise_pos, proc_noise_vel, output ready);
endinterface

interface kcv_out_if import kcv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ChanW-1:0]        out_channel;
  logic signed [DataW-1:0] position;
  logic signed [DataW-1:0] velocity;
  logic [VarW-1:0]         pos_variance;
  logic                    degenerate;
  modport source (output valid, out_channel, position, velocity, pos_variance,
                  degenerate, input ready);
  modport sink (input valid, out_channel, position, velocity, pos_variance,
                degenerate, output ready);
endinterface
`default_nettype wire

FILE: rtl/kcv_div.sv
`default_nettype none
module kcv_div import kcv_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire kcv_div_req_t            req_i,
  output logic                         done_o,
  output logic signed [DataW-1:0]      quot_o
);

  localparam int CntW = $clog2(DivW);
  localparam logic [CntW-1:0] CntLast = CntW'(DivW - 1);

  logic            busy_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] num_q;
  logic [31:0]     rem_q, den_q;
  logic [32:0]     rem_sh, rem_sub;
  logic            ge;
  logic [DivW:0]   q_signed;

  assign rem_sh  = {rem_q, num_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.mag;
      den_q <= req_i.den;
      neg_q <= req_i.neg;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DivW-2:0], ge};
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  assign q_signed = neg_q ? -{1'b0, num_q} : {1'b0, num_q};
  assign quot_o   = sat32(64'($signed(q_signed)));
  assign done_o   = done_q;

endmodule
`default_nettype wire

FILE: rtl/kcv_front.sv
`default_nettype none
module kcv_front import kcv_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kcv_in_if.sink     in_i,
  input  wire logic  pop_i,
  output kcv_q_sts_t sts_o,
  output kcv_item_t  item_o
);

  kcv_item_t  ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, in_range;
  kcv_item_t  item_in;

  assign in_range = 32'(in_i.channel) < CHANNELS;
  assign in_i.ready = cnt_q != 2'd2;
  assign push = in_i.valid && in_i.ready && in_range;

  assign item_in = '{action: in_i.action, channel: in_i.channel,
                     measurement: in_i.measurement, meas_noise: in_i.meas_noise,
                     proc_noise_pos: in_i.proc_noise_pos,
                     proc_noise_vel: in_i.proc_noise_vel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= item_in;
    end
  end

  assign sts_o.valid = cnt_q != 2'd0;
  assign sts_o.full  = cnt_q == 2'd2;
  assign item_o      = ent_q[rp_q];

endmodule
`default_nettype wire

FILE: rtl/kcv_back.sv
`default_nettype none
module kcv_back import kcv_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [TsW-1:0]  ts_i,
  input  wire kcv_q_sts_t      q_sts_i,
  input  wire kcv_item_t       q_item_i,
  output logic                 pop_o,
  kcv_out_if.source            out_o,
  output kcv_bk_sts_t          sts_o
);

  localparam int AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_PREP = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_CALC = 6'b010000,
    ST_FIN  = 6'b100000
  } kcv_state_e;

  kcv_state_e st_q, st_d;

  kcv_row_t   mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  kcv_row_t   rd_q, row, nrow;
  logic       rd_vld_q;
  kcv_item_t  item_q;
  logic [6:0] ch_ext;
  logic [AddrW-1:0] addr;

  logic signed [DataW-1:0] ts, innov_q, k1_q, k2_q, mul_a, mul_b;
  logic signed [DataW-1:0] res_q [5];
  logic signed [63:0]      prod_q, s_val;
  logic [2:0]              step_q;
  logic                    degen_q, s_pos, out_free, load;
  logic [31:0]             p11_mag, p12_mag;
  kcv_div_req_t            req1, req2;
  logic                    done1, done2, div_done;
  logic signed [DataW-1:0] quot1, quot2;
  logic signed [DataW-1:0] pos, vel;

  logic                    ov_q, od_q;
  logic [ChanW-1:0]        och_q;
  logic signed [DataW-1:0] opos_q, ovel_q;
  logic [VarW-1:0]         ovar_q;

  assign ch_ext = 7'(item_q.channel);
  assign addr   = ch_ext[AddrW-1:0];
  assign row    = rd_vld_q ? rd_q : '0;
  assign ts     = $signed({11'b0, ts_i});

  assign s_val   = 64'(row.p11) + $signed(64'(item_q.meas_noise));
  assign s_pos   = s_val > 64'sd0;
  assign p11_mag = row.p11[31] ? (~row.p11 + 32'd1) : row.p11;
  assign p12_mag = row.p12[31] ? (~row.p12 + 32'd1) : row.p12;

  always_comb begin
    req1 = '0;
    req2 = '0;
    if (st_q == ST_PREP && item_q.action == ActUpdate && s_pos) begin
      req1 = '{start: 1'b1, neg: row.p11[31], mag: {p11_mag, 16'b0}, den: s_val[31:0]};
      req2 = '{start: 1'b1, neg: row.p12[31], mag: {p12_mag, 16'b0}, den: s_val[31:0]};
    end
  end

  kcv_div u_div_k1 (.clk_i, .rst_ni, .req_i(req1), .done_o(done1), .quot_o(quot1));
  kcv_div u_div_k2 (.clk_i, .rst_ni, .req_i(req2), .done_o(done2), .quot_o(quot2));

  assign div_done = done1 && done2;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (item_q.action == ActPredict) begin
      case (step_q)
        3'd0: begin mul_a = row.p22;    mul_b = ts; end
        3'd1: begin mul_a = ts;         mul_b = row.p12; end
        3'd2: begin mul_a = ts;         mul_b = row.est_vel; end
        3'd3: begin mul_a = res_q[0];   mul_b = ts; end
        3'd4: begin mul_a = ts;         mul_b = row.p22; end
        default: begin mul_a = '0;      mul_b = '0; end
      endcase
    end else begin
      case (step_q)
        3'd0: begin mul_a = k1_q; mul_b = innov_q; end
        3'd1: begin mul_a = k2_q; mul_b = innov_q; end
        3'd2: begin mul_a = k2_q; mul_b = row.p12; end
        3'd3: begin mul_a = k1_q; mul_b = row.p12; end
        3'd4: begin mul_a = k1_q; mul_b = row.p11; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    nrow = row;
    if (item_q.action == ActPredict) begin
      nrow.pred_vel = row.est_vel;
      nrow.pred_pos = sat32(64'(row.est_pos) + 64'(res_q[2]));
      nrow.p11 = sat32(64'(row.p11) + (64'(res_q[1]) <<< 1) + 64'(res_q[3])
                       + $signed(64'(item_q.proc_noise_pos)));
      nrow.p12 = sat32(64'(row.p12) + 64'(res_q[4]));
      nrow.p22 = sat32(64'(row.p22) + $signed(64'(item_q.proc_noise_vel)));
      pos = nrow.pred_pos;
      vel = nrow.pred_vel;
    end else begin
      nrow.est_pos = sat32(64'(row.pred_pos) + 64'(res_q[0]));
      nrow.est_vel = sat32(64'(row.pred_vel) + 64'(res_q[1]));
      nrow.p22 = sat32(64'(row.p22) - 64'(res_q[2]));
      nrow.p12 = sat32(64'(row.p12) - 64'(res_q[3]));
      nrow.p11 = sat32(64'(row.p11) - 64'(res_q[4]));
      pos = nrow.est_pos;
      vel = nrow.est_vel;
    end
  end

  assign out_free = !ov_q || out_o.ready;
  assign load     = st_q == ST_FIN && out_free;
  assign pop_o    = st_q == ST_IDLE && q_sts_i.valid;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (q_sts_i.valid) st_d = ST_READ;
      ST_READ: st_d = ST_PREP;
      ST_PREP: st_d = (item_q.action == ActUpdate && s_pos) ? ST_DIV : ST_CALC;
      ST_DIV:  if (div_done) st_d = ST_CALC;
      ST_CALC: if (step_q == 3'd5) st_d = ST_FIN;
      ST_FIN:  if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) begin
        vld_q[addr] <= 1'b1;
        ov_q        <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_READ) begin
      rd_q     <= mem_q[addr];
      rd_vld_q <= vld_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mem_q[addr] <= nrow;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_item_i;
    end
    if (st_q == ST_PREP) begin
      innov_q <= sat32(64'(item_q.measurement) - 64'(row.pred_pos));
      k1_q    <= '0;
      k2_q    <= '0;
      degen_q <= item_q.action == ActUpdate && !s_pos;
      step_q  <= '0;
    end
    if (st_q == ST_DIV && div_done) begin
      k1_q <= quot1;
      k2_q <= quot2;
    end
    if (st_q == ST_CALC) begin
      step_q <= step_q + 3'd1;
      prod_q <= mul_a * mul_b;
      if (step_q != 3'd0) begin
        res_q[step_q - 3'd1] <= qfix(prod_q);
      end
    end
    if (load) begin
      och_q  <= item_q.channel;
      opos_q <= pos;
      ovel_q <= vel;
      ovar_q <= nrow.p11[31] ? '0 : nrow.p11[VarW-1:0];
      od_q   <= degen_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_channel  = och_q;
  assign out_o.position     = opos_q;
  assign out_o.velocity     = ovel_q;
  assign out_o.pos_variance = ovar_q;
  assign out_o.degenerate   = od_q;

  assign sts_o.busy = st_q != ST_IDLE;
  assign sts_o.fin  = load;

endmodule
`default_nettype wire

FILE: rtl/kalman_cv_tracker_unit.sv
// Two-state constant-velocity Kalman tracker for up to CHANNELS channels in signed Q16.16.
// Items enter through a two-beat queue and are worked one at a time; results leave through
// an output register, so a new item is taken while a result waits. A predict item goes
// from the queue to the output register by a state read, five multiplies on one 32x32
// multiplier and a write-back. An update item with positive innovation covariance also
// runs the two gain divisions, side by side in serial dividers resolving one quotient bit
// per cycle. Per-channel state resets to zero at once through valid bits; sample_period
// may be written only while idle.
`default_nettype none
module kalman_cv_tracker_unit import kcv_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [TsW-1:0]  cfg_wdata_i,
  kcv_in_if.sink               in_i,
  kcv_out_if.source            out_o
);

  `include "kalman_cv_tracker_unit_macros.svh"

  logic [TsW-1:0] ts_q;
  kcv_q_sts_t     q_sts;
  kcv_item_t      q_item;
  kcv_bk_sts_t    bk_sts;
  logic           pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TsReset;
    end else if (cfg_we_i) begin
      ts_q <= cfg_wdata_i;
    end
  end

  kcv_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i, .rst_ni, .in_i, .pop_i(pop), .sts_o(q_sts), .item_o(q_item)
  );

  kcv_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i, .rst_ni, .ts_i(ts_q), .q_sts_i(q_sts), .q_item_i(q_item),
    .pop_o(pop), .out_o, .sts_o(bk_sts)
  );

  `KCV_ASSERT_NEXT(a_idle_takes_beat, q_sts.valid && !bk_sts.busy, bk_sts.busy, "beat not taken")
  `KCV_ASSERT_SAME(a_out_from_fin, $rose(out_o.valid), $past(bk_sts.fin), "result without fin")
  `KCV_ASSERT_SAME(a_pop_nonempty, pop, q_sts.valid, "pop from empty queue")
  `KCV_ASSERT_SAME(a_full_no_ready, q_sts.full, !in_i.ready, "ready while queue full")

endmodule
`default_nettype wire

FILE: dv/kalman_cv_tracker_unit_tb.sv
module kalman_cv_tracker_unit_tb;
  import kcv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ChanW-1:0]        chan;
    logic signed [DataW-1:0] pos;
    logic signed [DataW-1:0] vel;
    logic [VarW-1:0]         pvar;
    logic                    degen;
  } track_out_t;

  class track_scoreboard;
    logic signed [DataW-1:0] est_pos[8];
    logic signed [DataW-1:0] est_vel[8];
    logic signed [DataW-1:0] pred_pos[8];
    logic signed [DataW-1:0] pred_vel[8];
    logic signed [DataW-1:0] p11_q[8];
    logic signed [DataW-1:0] p12_q[8];
    logic signed [DataW-1:0] p22_q[8];
    logic [TsW-1:0]          period;
    track_out_t              pending_q[$];
    int                      errors;

    function void clear();
      for (int i = 0; i < 8; i++) begin
        est_pos[i] = '0; est_vel[i] = '0; pred_pos[i] = '0; pred_vel[i] = '0;
        p11_q[i] = '0; p12_q[i] = '0; p22_q[i] = '0;
      end
      period = TsReset;
      errors = 0;
    endfunction

    function logic signed [DataW-1:0] clamp(longint v);
      if (v > 64'sh7fffffff) return 32'sh7fffffff;
      if (v < -64'sh80000000) return 32'sh80000000;
      return v[DataW-1:0];
    endfunction

    function logic signed [DataW-1:0] qprod(longint a, longint b);
      longint p;
      p = a * b;
      return clamp(p >>> 16);
    endfunction

    function void note_item(kcv_item_t it);
      int ch;
      longint ts, p11, p12, p22, innov, s, k1, k2;
      track_out_t r;
      ch = it.channel;
      ts = longint'(period);
      p11 = p11_q[ch]; p12 = p12_q[ch]; p22 = p22_q[ch];
      r.degen = 1'b0;
      if (it.action == ActPredict) begin
        pred_vel[ch] = est_vel[ch];
        pred_pos[ch] = clamp(longint'(est_pos[ch]) + qprod(ts, est_vel[ch]));
        p11_q[ch] = clamp(p11 + 2 * longint'(qprod(ts, p12))
                          + longint'(qprod(qprod(p22, ts), ts))
                          + longint'(it.proc_noise_pos));
        p12_q[ch] = clamp(p12 + qprod(ts, p22));
        p22_q[ch] = clamp(p22 + longint'(it.proc_noise_vel));
        r.pos = pred_pos[ch];
        r.vel = pred_vel[ch];
      end else begin
        innov = clamp(longint'(it.measurement) - longint'(pred_pos[ch]));
        s = p11 + longint'(it.meas_noise);
        k1 = 0; k2 = 0;
        if (s > 0) begin
          k1 = clamp((p11 * 65536) / s);
          k2 = clamp((p12 * 65536) / s);
        end else begin
          r.degen = 1'b1;
        end
        est_pos[ch] = clamp(longint'(pred_pos[ch]) + qprod(k1, innov));
        est_vel[ch] = clamp(longint'(pred_vel[ch]) + qprod(k2, innov));
        p22_q[ch] = clamp(p22 - qprod(k2, p12));
        p12_q[ch] = clamp(p12 - qprod(k1, p12));
        p11_q[ch] = clamp(p11 - qprod(k1, p11));
        r.pos = est_pos[ch];
        r.vel = est_vel[ch];
      end
      r.chan = it.channel;
      r.pvar = (p11_q[ch] < 0) ? '0 : p11_q[ch][VarW-1:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(track_out_t got);
      track_out_t w;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat on channel %0d", got.chan);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (got.chan !== w.chan) begin
        $error("out_channel exp %0d got %0d", w.chan, got.chan); errors++;
      end
      if (got.pos !== w.pos) begin
        $error("position exp %0d got %0d", w.pos, got.pos); errors++;
      end
      if (got.vel !== w.vel) begin
        $error("velocity exp %0d got %0d", w.vel, got.vel); errors++;
      end
      if (got.pvar !== w.pvar) begin
        $error("pos_variance exp %0d got %0d", w.pvar, got.pvar); errors++;
      end
      if (got.degen !== w.degen) begin
        $error("degenerate exp %0d got %0d", w.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TsW-1:0] cfg_wdata_i = '0;
  bit quiet = 1'b0;
  longint cycles = 0;
  track_scoreboard sb;

  kcv_in_if  in_bus ();
  kcv_out_if out_bus ();

  kalman_cv_tracker_unit #(.CHANNELS(8)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("kalman_cv_tracker_unit: mismatch");
      $finish;
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.action = ActPredict;
    in_bus.channel = '0;
    in_bus.measurement = '0;
    in_bus.meas_noise = '0;
    in_bus.proc_noise_pos = '0;
    in_bus.proc_noise_vel = '0;
    out_bus.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_bus.ready <= quiet || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    track_out_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.chan = out_bus.out_channel;
      got.pos = out_bus.position;
      got.vel = out_bus.velocity;
      got.pvar = out_bus.pos_variance;
      got.degen = out_bus.degenerate;
      sb.check_result(got);
    end
  end

  task automatic push_item(kcv_item_t it);
    while (!quiet && $urandom_range(99) < 12) begin
      @(negedge clk_i);
      in_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid = 1'b1;
    in_bus.action = it.action;
    in_bus.channel = it.channel;
    in_bus.measurement = it.measurement;
    in_bus.meas_noise = it.meas_noise;
    in_bus.proc_noise_pos = it.proc_noise_pos;
    in_bus.proc_noise_vel = it.proc_noise_vel;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    sb.note_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_period(logic [TsW-1:0] ts);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = ts;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.period = ts;
  endtask

  function automatic kcv_item_t make_item(logic act, int ch, longint z, longint r,
                                          longint qp, longint qv);
    kcv_item_t it;
    it.action = act;
    it.channel = ch[ChanW-1:0];
    it.measurement = z[DataW-1:0];
    it.meas_noise = r[VarW-1:0];
    it.proc_noise_pos = qp[VarW-1:0];
    it.proc_noise_vel = qv[VarW-1:0];
    return it;
  endfunction

  function automatic kcv_item_t rand_item();
    kcv_item_t it;
    it.action = 1'($urandom_range(1));
    it.channel = ChanW'($urandom_range(7));
    if ($urandom_range(9) == 0) begin
      it.measurement = $urandom();
      it.meas_noise = VarW'($urandom());
      it.proc_noise_pos = VarW'($urandom());
      it.proc_noise_vel = VarW'($urandom());
    end else begin
      it.measurement = $urandom_range(32'h00ffffff) - 32'h00800000;
      it.meas_noise = VarW'($urandom_range(32'h0003ffff));
      it.proc_noise_pos = VarW'($urandom_range(32'h0003ffff));
      it.proc_noise_vel = VarW'($urandom_range(32'h0000ffff));
    end
    return it;
  endfunction

  initial begin
    logic [TsW-1:0] periods[6];
    periods = '{21'd655, 21'd0, 21'h1fffff, 21'd65536, 21'd1048576, 21'd3277};
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_item(make_item(ActPredict, 0, 0, 0, 0, 0));
    push_item(make_item(ActUpdate, 0, 12345, 0, 0, 0));
    push_item(make_item(ActPredict, 1, 0, 0, 64'h7fffffff, 64'h7fffffff));
    push_item(make_item(ActUpdate, 1, 64'h7fffffff, 0, 0, 0));
    push_item(make_item(ActPredict, 1, 0, 0, 64'h7fffffff, 64'h7fffffff));
    push_item(make_item(ActUpdate, 1, -64'sh80000000, 64'h7fffffff, 0, 0));
    for (int c = 2; c < 8; c++) begin
      push_item(make_item(ActPredict, c, 0, 0, 65536 * c, 4096 * c));
      push_item(make_item(ActUpdate, c, 65536 * (c - 5), 65536, 0, 0));
    end
    push_item(make_item(ActUpdate, 7, -64'sh80000000, 0, 0, 0));
    push_item(make_item(ActPredict, 7, 0, 64'h7fffffff, 64'h7fffffff, 0));
    push_item(make_item(ActUpdate, 7, 64'h7fffffff, 64'h7fffffff, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_period(periods[ph]);
      quiet = (ph == 3);
      for (int n = 0; n < 180; n++) begin
        if (ph == 2 && n == 90) drain();
        push_item(rand_item());
      end
      quiet = 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("kalman_cv_tracker_unit: match");
    end else begin
      $display("kalman_cv_tracker_unit: mismatch");
    end
    $finish;
  end
endmodule
